// ===== hdl/rlrd_pkg.sv =====
package rlrd_pkg;

	localparam int PayloadBytes = 46;
	localparam int LenW = 6;

	localparam logic [7:0] FN_TRANSMIT  = 8'h07;
	localparam logic [7:0] FN_RECEIVE   = 8'h1E;
	localparam logic [7:0] FN_OPMODE    = 8'h2A;
	localparam logic [7:0] FN_TELEMETRY = 8'h2D;
	localparam logic [7:0] ACT_ACK      = 8'h00;
	localparam logic [7:0] ACT_EXEC     = 8'h4B;
	localparam logic [7:0] ACT_NAK      = 8'h7F;
	localparam logic [7:0] TELEM_ID_RSSI = 8'h06;
	localparam logic [7:0] CRC_POLY_RESET = 8'h07;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TAKE = 1'b1;

	localparam logic [2:0] KIND_TX_ACK  = 3'd0;
	localparam logic [2:0] KIND_TX_NAK  = 3'd1;
	localparam logic [2:0] KIND_OPM_ACK = 3'd2;
	localparam logic [2:0] KIND_OPM_NAK = 3'd3;
	localparam logic [2:0] KIND_OPMODE  = 3'd4;
	localparam logic [2:0] KIND_RX      = 3'd5;
	localparam logic [2:0] KIND_TELEM   = 3'd6;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_TX_ACT   = 9'b000000010,
		ST_OPM_ACT  = 9'b000000100,
		ST_OPM_DATA = 9'b000001000,
		ST_RX_ACT   = 9'b000010000,
		ST_RX_DATA  = 9'b000100000,
		ST_TM_ACT   = 9'b001000000,
		ST_TM_ID    = 9'b010000000,
		ST_TM_DATA  = 9'b100000000
	} parse_state_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic            package_valid;
		logic [2:0]      package_kind;
		logic [LenW-1:0] package_length;
		logic            error_pulse;
		logic [15:0]     error_count;
		logic            pending;
		logic            data_valid;
		logic [LenW-1:0] data_index;
		logic [7:0]      data_byte;
	} out_item_t;

	function automatic logic [7:0] crc8_feed(input logic [7:0] residue, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] c;
		c = residue ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hdl/rlrd_in_if.sv =====
interface rlrd_in_if import rlrd_pkg::*;;
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/rlrd_out_if.sv =====
interface rlrd_out_if import rlrd_pkg::*;;
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/radio_link_response_deframer_top.sv =====
// Response deframer for a transceiver UART link. Each transfer on rx carries either a received
// byte (cmd 0) or a consumer take of the pending package (cmd 1), and yields exactly one result
// transfer on res. Frames are function byte, action byte, then for opmode EXEC, receive EXEC
// and telemetry ACK the data bytes ending in a CRC-8 (MSB first, init 0, polynomial from the
// configuration register, reset 0x07). An item passes an input register and is parsed into the
// result register by the single parse-and-CRC step between those registers, one item per cycle
// while res accepts them. Write the polynomial only while idle.
module radio_link_response_deframer_top import rlrd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	rlrd_in_if.sink    rx,
	rlrd_out_if.source res
);

	logic            valid_s1;
	in_item_t        item_s1;
	logic            res_valid_q;
	out_item_t       res_q;
	logic [7:0]      poly_q;
	parse_state_t    state_q, state_d;
	logic [LenW-1:0] left_q, left_d;
	logic [LenW-1:0] pos_q, pos_d;
	logic [7:0]      crc_q, crc_d;
	logic            pend_q, pend_d;
	logic [15:0]     err_q, err_d;

	logic            res_adv;
	logic            step;
	logic [7:0]      b;
	logic            raise;
	logic [2:0]      kind;
	logic [LenW-1:0] len;
	logic            err;
	logic            store;
	logic            restart;
	logic [LenW-1:0] store_pos;
	logic [7:0]      crc_base;
	logic [7:0]      crc_fed;
	out_item_t       res_d;

	assign res_adv  = !res_valid_q || res.ready;
	assign rx.ready = !valid_s1 || res_adv;
	assign step     = valid_s1 && res_adv;
	assign b        = item_s1.rx_byte;

	assign store_pos = restart ? '0 : pos_q;
	assign crc_base  = restart ? 8'h00 : crc_q;
	assign crc_fed   = crc8_feed(crc_base, b, poly_q);

	always_comb begin
		state_d = state_q;
		left_d  = left_q;
		pos_d   = pos_q;
		crc_d   = crc_q;
		pend_d  = pend_q;
		raise   = 1'b0;
		kind    = KIND_TX_ACK;
		len     = '0;
		err     = 1'b0;
		store   = 1'b0;
		restart = 1'b0;
		res_d   = '0;
		if (item_s1.cmd == CMD_TAKE) begin
			pend_d = 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (b == FN_RECEIVE) begin
						state_d = ST_RX_ACT;
					end else if (b == FN_TRANSMIT) begin
						state_d = ST_TX_ACT;
					end else if (b == FN_TELEMETRY) begin
						state_d = ST_TM_ACT;
					end else if (b == FN_OPMODE) begin
						state_d = ST_OPM_ACT;
					end else begin
						err = 1'b1;
					end
				end
				ST_TX_ACT: begin
					state_d = ST_IDLE;
					if (b == ACT_ACK) begin
						raise = 1'b1;
						kind  = KIND_TX_ACK;
					end else if (b == ACT_NAK) begin
						raise = 1'b1;
						kind  = KIND_TX_NAK;
					end else begin
						err = 1'b1;
					end
				end
				ST_OPM_ACT: begin
					state_d = ST_IDLE;
					if (b == ACT_ACK) begin
						raise = 1'b1;
						kind  = KIND_OPM_ACK;
					end else if (b == ACT_NAK) begin
						raise = 1'b1;
						kind  = KIND_OPM_NAK;
					end else if (b == ACT_EXEC) begin
						state_d = ST_OPM_DATA;
						left_d  = LenW'(2);
						pos_d   = '0;
						crc_d   = 8'h00;
					end else begin
						err = 1'b1;
					end
				end
				ST_RX_ACT: begin
					if (b == ACT_EXEC) begin
						state_d = ST_RX_DATA;
						left_d  = LenW'(PayloadBytes + 1);
						pos_d   = '0;
						crc_d   = 8'h00;
					end else begin
						err     = 1'b1;
						state_d = ST_IDLE;
					end
				end
				ST_TM_ACT: begin
					if (b == ACT_ACK) begin
						state_d = ST_TM_ID;
					end else begin
						err     = 1'b1;
						state_d = ST_IDLE;
					end
				end
				ST_TM_ID: begin
					state_d = ST_TM_DATA;
					left_d  = (b == TELEM_ID_RSSI) ? LenW'(3) : LenW'(2);
					restart = 1'b1;
					store   = 1'b1;
				end
				ST_OPM_DATA, ST_RX_DATA, ST_TM_DATA: begin
					store = 1'b1;
					if (left_q > LenW'(1)) begin
						left_d = left_q - LenW'(1);
					end else begin
						left_d  = '0;
						state_d = ST_IDLE;
						if (crc_fed == 8'h00) begin
							raise = 1'b1;
							if (state_q == ST_OPM_DATA) begin
								kind = KIND_OPMODE;
								len  = LenW'(1);
							end else if (state_q == ST_RX_DATA) begin
								kind = KIND_RX;
								len  = LenW'(PayloadBytes);
							end else begin
								kind = KIND_TELEM;
								len  = pos_q - LenW'(1);
							end
						end else begin
							err = 1'b1;
						end
					end
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
			if (store) begin
				res_d.data_valid = 1'b1;
				res_d.data_index = store_pos;
				res_d.data_byte  = b;
				pos_d            = store_pos + LenW'(1);
				crc_d            = crc_fed;
			end
			if (raise) begin
				if (!pend_q) begin
					pend_d               = 1'b1;
					res_d.package_valid  = 1'b1;
					res_d.package_kind   = kind;
					res_d.package_length = len;
				end else begin
					err = 1'b1;
				end
			end
		end
		err_d             = (err && (err_q != 16'hFFFF)) ? err_q + 16'd1 : err_q;
		res_d.error_pulse = err;
		res_d.error_count = err_d;
		res_d.pending     = pend_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q      <= CRC_POLY_RESET;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			state_q     <= ST_IDLE;
			left_q      <= '0;
			pos_q       <= '0;
			crc_q       <= 8'h00;
			pend_q      <= 1'b0;
			err_q       <= 16'd0;
		end else begin
			if (cfg_we) begin
				poly_q <= cfg_wdata;
			end
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (res_adv) begin
				res_valid_q <= valid_s1;
			end
			if (step) begin
				state_q <= state_d;
				left_q  <= left_d;
				pos_q   <= pos_d;
				crc_q   <= crc_d;
				pend_q  <= pend_d;
				err_q   <= err_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1 <= rx.payload;
		end
		if (step) begin
			res_q <= res_d;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

`ifndef SYNTHESIS
	a_pkg_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.payload.package_valid |-> res.payload.pending)
		else $error("package raised without pending set");

	a_pkg_or_error: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.payload.package_valid && res.payload.error_pulse))
		else $error("package and error on the same transfer");

	a_err_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		err_q >= $past(err_q))
		else $error("error total decreased");
`endif

endmodule
